// ===== src/stad_pkg.sv =====
// Shared types and constants for the S-curve time-at-distance solver.
`default_nettype none
package stad_pkg;
  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int IW = 64;
  localparam int TOL_BITS = 16;
  localparam int LIM_BITS = 7;
  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] REG_TOLERANCE = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ITER_LIMIT = 1'd1;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BEYOND = 2'd1;
  localparam logic [1:0] ST_NOCONV = 2'd2;
  localparam logic [1:0] ST_ZERO_DERIV = 2'd3;
  localparam logic signed [IW-1:0] SMAX = {1'b0, {(IW-1){1'b1}}};
  localparam logic signed [IW-1:0] SMIN = -SMAX;
  // ceil(2^66 / 6): (n * DIV6_MAGIC) >> 66 == n / 6 for any 64-bit n
  localparam logic [IW-1:0] DIV6_MAGIC = 64'hAAAA_AAAA_AAAA_AAAB;

  typedef enum logic [1:0] {OP_MUL, OP_DIV, OP_DIV6} alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_ctl_t;

  function automatic logic signed [IW-1:0] sadd(input logic signed [IW-1:0] a,
                                                input logic signed [IW-1:0] b);
    logic signed [IW:0] s;
    s = $signed({a[IW-1], a}) + $signed({b[IW-1], b});
    if (s > $signed({1'b0, SMAX})) return SMAX;
    if (s < $signed({SMIN[IW-1], SMIN})) return SMIN;
    return s[IW-1:0];
  endfunction

  function automatic logic [IW-1:0] mag(input logic signed [IW-1:0] x);
    return x[IW-1] ? IW'(-x) : x;
  endfunction
endpackage
`default_nettype wire

// ===== src/stad_if.sv =====
// Valid/ready channel interfaces for solver input and result beats.
`default_nettype none
interface stad_in_if import stad_pkg::*; (input logic clk);
  logic valid;
  logic ready;
  logic signed [WORD_BITS-1:0] target_distance;
  logic signed [WORD_BITS-1:0] start_velocity;
  logic signed [WORD_BITS-1:0] start_accel;
  logic signed [WORD_BITS-1:0] jerk;
  logic [WORD_BITS-2:0] time_bound;
  modport source (output valid, target_distance, start_velocity, start_accel, jerk,
                  time_bound, input ready);
  modport sink (input valid, target_distance, start_velocity, start_accel, jerk,
                time_bound, output ready);
endinterface

interface stad_out_if import stad_pkg::*; (input logic clk);
  logic valid;
  logic ready;
  logic [WORD_BITS-2:0] time_found;
  logic [1:0] status;
  modport source (output valid, time_found, status, input ready);
  modport sink (input valid, time_found, status, output ready);
endinterface
`default_nettype wire

// ===== src/stad_alu.sv =====
// Shared multi-cycle unit: saturating fixed-point multiply, divide by 6 and bit-serial divide.
`default_nettype none
module stad_alu import stad_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire alu_ctl_t             ctl,
  input  wire logic signed [IW-1:0] op_x,
  input  wire logic signed [IW-1:0] op_y,
  output logic                      done,
  output logic signed [IW-1:0]      result
);
  // multiply: four 32x32 partial products, one per cycle
  // divide by 6: same multiply against a reciprocal, high bits kept
  // divide: 128 restoring steps, one bit per cycle
  logic        busy_r, busy_nxt;
  alu_op_t     op_r, op_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic        neg_r, neg_nxt;
  logic [IW-1:0] ux_r, ux_nxt, uy_r, uy_nxt;
  logic [2*IW-1:0] acc_r, acc_nxt;
  logic [IW:0] rem_r, rem_nxt;
  logic        over_r, over_nxt;
  logic        done_nxt;
  logic signed [IW-1:0] result_nxt;

  logic [31:0] pa, pb;
  logic [63:0] pp;
  logic [IW:0] rsh, rsub;
  logic [2*IW-1:0] prod_sh;
  logic [IW-1:0] m;

  always_comb begin
    busy_nxt = busy_r; op_nxt = op_r; cnt_nxt = cnt_r; neg_nxt = neg_r;
    ux_nxt = ux_r; uy_nxt = uy_r; acc_nxt = acc_r; rem_nxt = rem_r; over_nxt = over_r;
    done_nxt = 1'b0; result_nxt = result;
    pa = cnt_r[0] ? ux_r[63:32] : ux_r[31:0];
    pb = cnt_r[1] ? uy_r[63:32] : uy_r[31:0];
    pp = pa * pb;
    rsh = {rem_r[IW-1:0], acc_r[2*IW-1]};
    rsub = rsh - {1'b0, uy_r};
    prod_sh = acc_r >> FRAC_BITS;
    m = '0;
    if (!busy_r) begin
      if (ctl.start) begin
        busy_nxt = 1'b1; op_nxt = ctl.op; cnt_nxt = '0;
        neg_nxt = op_x[IW-1] ^ op_y[IW-1];
        ux_nxt = mag(op_x);
        uy_nxt = (ctl.op == OP_DIV6) ? DIV6_MAGIC : mag(op_y);
        acc_nxt = (ctl.op == OP_DIV) ? ({{IW{1'b0}}, mag(op_x)} << FRAC_BITS) : '0;
        rem_nxt = '0; over_nxt = 1'b0;
      end
    end else if (op_r inside {OP_MUL, OP_DIV6}) begin
      if (cnt_r < 8'd4) begin
        acc_nxt = acc_r + ({64'd0, pp} << (32 * (int'(cnt_r[0]) + int'(cnt_r[1]))));
        cnt_nxt = cnt_r + 8'd1;
      end else begin
        if (op_r == OP_DIV6) m = {2'b00, acc_r[2*IW-1:IW+2]};
        else if (prod_sh[2*IW-1:IW-1] != '0) m = SMAX;
        else m = prod_sh[IW-1:0];
        result_nxt = neg_r ? IW'(-m) : m;
        done_nxt = 1'b1; busy_nxt = 1'b0;
      end
    end else begin
      if (cnt_r < 8'd128) begin
        acc_nxt = {acc_r[2*IW-2:0], 1'b0};
        if (!rsub[IW]) begin
          rem_nxt = rsub;
          if (cnt_r <= 8'd64) over_nxt = 1'b1;
          else acc_nxt[0] = 1'b1;
        end else rem_nxt = rsh;
        cnt_nxt = cnt_r + 8'd1;
      end else begin
        m = over_r ? SMAX : {1'b0, acc_r[IW-2:0]};
        result_nxt = neg_r ? IW'(-m) : m;
        done_nxt = 1'b1; busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done <= done_nxt;
    end
    op_r <= op_nxt; cnt_r <= cnt_nxt; neg_r <= neg_nxt; ux_r <= ux_nxt; uy_r <= uy_nxt;
    acc_r <= acc_nxt; rem_r <= rem_nxt; over_r <= over_nxt; result <= result_nxt;
  end
endmodule
`default_nettype wire

// ===== src/scurve_time_at_distance.sv =====
// Top level of the S-curve time-at-distance Newton-Raphson solver.
// One beat in, one beat out. The block is busy for the whole solve and all
// multiplies and divides run on one shared unit. D(t) costs three multiplies
// and one divide by 6 plus a check state; a Newton step adds D'(t) (two
// multiplies), a zero test, the divide and an update. A solve runs up to
// iteration_limit steps, plus the wait for the result to be taken; short
// distances and hits at the bound finish without a Newton step.
// Configuration writes are to be made only when idle; the block itself does
// not enforce this.
`default_nettype none
module scurve_time_at_distance import stad_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [TOL_BITS-1:0]     cfg_data,
  stad_in_if.sink                      in_ch,
  stad_out_if.source                   out_ch
);
  typedef enum logic [4:0] {
    S_IDLE, S_D1, S_D6, S_D2, S_D3, S_CHK_MAX, S_CHK, S_S1, S_S2, S_S3, S_DIV,
    S_UPD, S_OUT, S_WAIT
  } state_t;

  state_t state_r;
  logic [TOL_BITS-1:0] tol_r;
  logic [LIM_BITS-1:0] lim_r;
  logic signed [IW-1:0] d_r, v_r, a_r, j_r, bnd_r, t_r, x_r, tmp_r;
  logic [LIM_BITS-1:0] k_r;
  logic at_max_r, waiting_r;
  logic [WORD_BITS-2:0] tf_r;
  logic [1:0] st_r;
  logic out_v_r;

  alu_ctl_t ctl;
  logic signed [IW-1:0] ax, ay, ares;
  logic adone;

  stad_alu u_alu (.clk(clk), .rst_n(rst_n), .ctl(ctl), .op_x(ax), .op_y(ay),
                  .done(adone), .result(ares));

  logic signed [IW-1:0] tcur, resid, dv;
  logic [IW-1:0] tmax;
  assign tmax = {{(IW-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
  assign tcur = at_max_r ? bnd_r : t_r;
  assign resid = sadd(ares, -d_r);
  assign dv = sadd(tmp_r, -d_r);

  function automatic logic signed [IW-1:0] rd(input logic signed [WORD_BITS-1:0] x);
    return IW'(x);
  endfunction

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = out_v_r;
  assign out_ch.time_found = tf_r;
  assign out_ch.status = st_r;

  always_comb begin
    ctl.start = 1'b0; ctl.op = OP_MUL; ax = tcur; ay = j_r;
    if (!waiting_r) begin
      case (state_r)
        S_D1, S_S1: begin ctl.start = 1'b1; end
        S_D6: begin ctl.start = 1'b1; ctl.op = OP_DIV6; ax = tmp_r; ay = '0; end
        S_D2: begin ctl.start = 1'b1; ay = sadd(a_r / 2, tmp_r); end
        S_D3: begin ctl.start = 1'b1; ay = sadd(v_r, tmp_r); end
        S_S2: begin ctl.start = 1'b1; ay = sadd(a_r, tmp_r / 2); end
        S_DIV: begin ctl.start = 1'b1; ctl.op = OP_DIV; ax = x_r; ay = tmp_r; end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; tol_r <= TOL_BITS'(66); lim_r <= LIM_BITS'(32);
      out_v_r <= 1'b0; waiting_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == REG_TOLERANCE) tol_r <= cfg_data;
      if (cfg_we && cfg_index == REG_ITER_LIMIT) lim_r <= cfg_data[LIM_BITS-1:0];
      if (ctl.start) waiting_r <= 1'b1;
      if (adone) waiting_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_ch.valid) begin
          d_r <= rd(in_ch.target_distance); v_r <= rd(in_ch.start_velocity);
          a_r <= rd(in_ch.start_accel); j_r <= rd(in_ch.jerk);
          bnd_r <= IW'(in_ch.time_bound); t_r <= IW'(in_ch.time_bound) / 2;
          k_r <= '0; at_max_r <= 1'b1; tf_r <= '0; st_r <= ST_OK;
          if (rd(in_ch.target_distance) < $signed({1'b0, {(IW-TOL_BITS-1){1'b0}}, tol_r}))
            state_r <= S_OUT;
          else state_r <= S_D1;
        end
        S_D1: if (adone) begin tmp_r <= ares; state_r <= S_D6; end
        S_D6: if (adone) begin tmp_r <= ares; state_r <= S_D2; end
        S_D2: if (adone) begin tmp_r <= ares; state_r <= S_D3; end
        S_D3: if (adone) begin
          tmp_r <= ares; x_r <= resid;
          state_r <= at_max_r ? S_CHK_MAX : S_CHK;
        end
        S_CHK_MAX: begin
          at_max_r <= 1'b0;
          if (mag(dv) < {{(IW-TOL_BITS){1'b0}}, tol_r}) begin
            tf_r <= bnd_r[WORD_BITS-2:0]; state_r <= S_OUT;
          end else if (tmp_r < d_r) begin
            st_r <= ST_BEYOND; state_r <= S_OUT;
          end else state_r <= S_D1;
        end
        S_CHK: begin
          if (mag(x_r) < {{(IW-TOL_BITS){1'b0}}, tol_r}) begin
            if (t_r[IW-1]) tf_r <= '0;
            else if ($unsigned(t_r) > tmax) tf_r <= tmax[WORD_BITS-2:0];
            else tf_r <= t_r[WORD_BITS-2:0];
            state_r <= S_OUT;
          end else if (k_r >= lim_r) begin
            st_r <= ST_NOCONV; state_r <= S_OUT;
          end else state_r <= S_S1;
        end
        S_S1: if (adone) begin tmp_r <= ares; state_r <= S_S2; end
        S_S2: if (adone) begin tmp_r <= sadd(v_r, ares); state_r <= S_S3; end
        S_S3: begin
          if (tmp_r == '0) begin st_r <= ST_ZERO_DERIV; state_r <= S_OUT; end
          else state_r <= S_DIV;
        end
        S_DIV: if (adone) begin tmp_r <= ares; state_r <= S_UPD; end
        S_UPD: begin
          t_r <= sadd(t_r, -tmp_r); k_r <= k_r + LIM_BITS'(1); state_r <= S_D1;
        end
        S_OUT: begin out_v_r <= 1'b1; state_r <= S_WAIT; end
        S_WAIT: if (out_ch.ready) begin out_v_r <= 1'b0; state_r <= S_IDLE; end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> state_r == S_WAIT) else $error("result beat outside wait");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && st_r != ST_OK) |-> tf_r == '0) else $error("nonzero time on error");
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |-> !waiting_r) else $error("unit restarted while busy");
endmodule
`default_nettype wire
